// File: hdl/otr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otr_pkg
// Types and constants shared by the overwriting event trace ring.
// ----------------------------------------------------------------------------
package otr_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_APPEND   = 2'd0;
    localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
    localparam logic [1:0] CMD_STATUS   = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  level;
        logic [63:0] stamp_ms;
        logic [63:0] payload;
        logic [6:0]  max_wanted;
    } otr_in_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] out_stamp_ms;
        logic [31:0] out_sequence;
        logic [2:0]  out_level;
        logic [63:0] out_payload;
        logic [31:0] total_written;
        logic [31:0] total_dropped;
        logic [5:0]  retained;
        logic        last;
    } otr_out_t;

    // One ring slot as stored in memory
    typedef struct packed {
        logic [63:0] stamp_ms;
        logic [31:0] sequence_num;
        logic [2:0]  level;
        logic [63:0] payload;
    } otr_entry_t;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] count;
    } otr_snap_req_t;

    typedef struct packed {
        logic valid;
        logic last;
    } otr_snap_out_t;

    typedef enum logic {
        SNAP_IDLE,
        SNAP_READ
    } otr_snap_state_t;

endpackage

// File: hdl/otr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module otr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/otr_snap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otr_snap
// Snapshot sequencer: walks the ring from the first requested slot, one read
// per cycle, and flags each word as it leaves the RAM read register.
// ----------------------------------------------------------------------------
module otr_snap
    import otr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  otr_snap_req_t               req,
    input  logic [$clog2(CAPACITY)-1:0] first_slot,
    output logic                        busy,
    output logic                        rd_en,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    output otr_snap_out_t               snap_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    otr_snap_state_t  state_reg, state_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             valid_reg, valid_next;
    logic             last_reg, last_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SNAP_IDLE:
            begin
                if (req.go)
                begin
                    state_next = SNAP_READ;
                end
            end
            SNAP_READ:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = SNAP_IDLE;
                end
            end
            default:
            begin
                state_next = SNAP_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = slot_reg;
        busy       = 1'b0;
        slot_next  = slot_reg;
        left_next  = left_reg;
        last_next  = 1'b0;
        case (state_reg)
            SNAP_IDLE:
            begin
                if (req.go)
                begin
                    slot_next = first_slot;
                    left_next = req.count;
                end
            end
            SNAP_READ:
            begin
                busy      = 1'b1;
                rd_en     = 1'b1;
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                left_next = left_reg - CNT_W'(1);
                last_next = (left_reg == CNT_W'(1));
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        valid_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SNAP_IDLE;
            left_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign snap_out.valid = valid_reg;
    assign snap_out.last  = last_reg;

    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> state_reg == SNAP_IDLE)
        else $error("snapshot request while walk in progress");

    a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> snap_out.valid)
        else $error("read issued without a word one cycle later");

    a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        snap_out.last |-> snap_out.valid)
        else $error("last flag on an empty cycle");

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SNAP_READ |-> left_reg != '0)
        else $error("walk running with no entries left");

endmodule

// File: hdl/overwriting_event_trace_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_event_trace_ring
// Event trace ring held in one RAM; overwrites the oldest entry when full.
// ----------------------------------------------------------------------------
// Append and clear leave busy low: one per cycle while no snapshot holds busy.
// Status: busy stays low, its word appears the cycle after the word is accepted.
// Snapshot of n = min(retained, max_wanted, 32) entries holds busy while the
// walk issues its n RAM reads; words come from the RAM read register, one per
// cycle, the final one flagged last. The receiver cannot stall the strobe.
// Reset clears the ring's counters and its oldest pointer; ring contents are not cleared.
module overwriting_event_trace_ring
    import otr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  otr_in_t  item,
    output logic     strobe,
    output otr_out_t result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int HW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [HW:0]   CAP_WIDE  = (HW + 1)'(CAPACITY);

    logic [AW-1:0] oldest_reg, oldest_next;
    logic [HW-1:0] held_reg, held_next;
    logic [31:0]   seq_reg, seq_next;
    logic [31:0]   written_reg, written_next;
    logic [31:0]   dropped_reg, dropped_next;
    logic          status_reg, status_next;

    logic          accept;
    logic          full;
    logic [HW:0]   tail_sum;
    logic [AW-1:0] tail_slot;
    logic [6:0]    held_ext;
    logic [6:0]    snap_min;
    logic [6:0]    snap_n;
    logic [HW-1:0] skip;
    logic [HW:0]   first_sum;
    logic [AW-1:0] first_slot;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    otr_entry_t    wr_entry;
    otr_entry_t    rd_entry;

    otr_snap_req_t snap_req;
    otr_snap_out_t snap_out;
    logic          snap_busy;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign accept = start && !busy;
    assign busy   = snap_busy;
    assign full   = (held_reg == HW'(CAPACITY));

    // slot after the newest entry, wrapped
    assign tail_sum  = (HW + 1)'(oldest_reg) + (HW + 1)'(held_reg);
    assign tail_slot = (tail_sum >= CAP_WIDE) ? AW'(tail_sum - CAP_WIDE) : AW'(tail_sum);

    // snapshot size and first slot to read
    assign held_ext   = 7'(held_reg);
    assign snap_min   = (held_ext < item.max_wanted) ? held_ext : item.max_wanted;
    assign snap_n     = (snap_min > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : snap_min;
    assign skip       = held_reg - HW'(snap_n);
    assign first_sum  = (HW + 1)'(oldest_reg) + (HW + 1)'(skip);
    assign first_slot = (first_sum >= CAP_WIDE) ? AW'(first_sum - CAP_WIDE)
                                                : AW'(first_sum);

    assign snap_req.go    = accept && item.command == CMD_SNAPSHOT && snap_n != '0;
    assign snap_req.count = CNT_W'(snap_n);

    always_comb
    begin
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        seq_next     = seq_reg;
        written_next = written_reg;
        dropped_next = dropped_reg;
        status_next  = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = tail_slot;
        if (accept)
        begin
            case (item.command)
                CMD_APPEND:
                begin
                    wr_en        = 1'b1;
                    seq_next     = seq_reg + 32'd1;
                    written_next = written_reg + 32'd1;
                    if (full)
                    begin
                        // overwrite the oldest and advance past it
                        wr_addr      = oldest_reg;
                        oldest_next  = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + AW'(1);
                        dropped_next = dropped_reg + 32'd1;
                    end
                    else
                    begin
                        held_next = held_reg + HW'(1);
                    end
                end
                CMD_STATUS:
                begin
                    status_next = 1'b1;
                end
                CMD_CLEAR:
                begin
                    oldest_next  = '0;
                    held_next    = '0;
                    seq_next     = '0;
                    written_next = '0;
                    dropped_next = '0;
                end
                default:
                begin
                    status_next = 1'b0;
                end
            endcase
        end
    end

    assign wr_entry.stamp_ms     = item.stamp_ms;
    assign wr_entry.sequence_num = seq_reg + 32'd1;
    assign wr_entry.level        = item.level;
    assign wr_entry.payload      = item.payload;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg  <= '0;
            held_reg    <= '0;
            seq_reg     <= '0;
            written_reg <= '0;
            dropped_reg <= '0;
            status_reg  <= 1'b0;
        end
        else
        begin
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            seq_reg     <= seq_next;
            written_reg <= written_next;
            dropped_reg <= dropped_next;
            status_reg  <= status_next;
        end
    end

    otr_ram #(
        .WIDTH ($bits(otr_entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    otr_snap #(
        .CAPACITY (CAPACITY)
    ) u_snap (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (snap_req),
        .first_slot (first_slot),
        .busy       (snap_busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .snap_out   (snap_out)
    );

    // counters hold through the status word's cycle, so read them live
    assign strobe = status_reg || snap_out.valid;

    always_comb
    begin
        if (status_reg)
        begin
            result.kind          = KIND_STATUS;
            result.out_stamp_ms  = '0;
            result.out_sequence  = '0;
            result.out_level     = '0;
            result.out_payload   = '0;
            result.total_written = written_reg;
            result.total_dropped = dropped_reg;
            result.retained      = 6'(held_reg);
            result.last          = 1'b1;
        end
        else
        begin
            result.kind          = KIND_ENTRY;
            result.out_stamp_ms  = rd_entry.stamp_ms;
            result.out_sequence  = rd_entry.sequence_num;
            result.out_level     = rd_entry.level;
            result.out_payload   = rd_entry.payload;
            result.total_written = '0;
            result.total_dropped = '0;
            result.retained      = '0;
            result.last          = snap_out.last;
        end
    end

    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(status_reg && snap_out.valid))
        else $error("status and snapshot word in the same cycle");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(CAPACITY))
        else $error("retained count above capacity");

    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !wr_en)
        else $error("ring write during snapshot walk");

endmodule

// File: dv/tb_overwriting_event_trace_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwriting_event_trace_ring
// Self-checking bench for the overwriting event trace ring. Drives append,
// snapshot, status and clear words with random gaps, keeps its own copy of
// the ring and counters, and compares every strobed word field by field.
// ----------------------------------------------------------------------------
module tb_overwriting_event_trace_ring;
    import otr_pkg::*;

    localparam int RING_DEPTH = CAPACITY_DEF;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    otr_in_t  item  = '0;
    logic     busy;
    logic     strobe;
    otr_out_t result;

    overwriting_event_trace_ring u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predicted ring contents and counters
    logic [63:0] ring_stamp   [RING_DEPTH];
    logic [31:0] ring_seq     [RING_DEPTH];
    logic [2:0]  ring_level   [RING_DEPTH];
    logic [63:0] ring_payload [RING_DEPTH];
    int          ring_oldest;
    int          ring_held;
    logic [31:0] seq_counter;
    logic [31:0] written_counter;
    logic [31:0] dropped_counter;

    otr_out_t pending_words[$];
    otr_out_t head_word;
    int       error_count = 0;
    int       words_sent  = 0;
    int       words_seen  = 0;
    bit       idle_on     = 1'b1;

    task automatic report_error(input string msg);
        if (error_count < 200)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void clear_trace_model();
        ring_oldest     = 0;
        ring_held       = 0;
        seq_counter     = '0;
        written_counter = '0;
        dropped_counter = '0;
    endfunction

    function automatic void predict_trace_words(input otr_in_t w);
        otr_out_t r;
        int       slot;
        int       n;
        int       first;
        case (w.command)
            CMD_APPEND:
            begin
                if (ring_held < RING_DEPTH)
                begin
                    slot = (ring_oldest + ring_held) % RING_DEPTH;
                    ring_held++;
                end
                else
                begin
                    // full: overwrite the oldest slot
                    slot = ring_oldest;
                    ring_oldest = (ring_oldest + 1) % RING_DEPTH;
                    dropped_counter = dropped_counter + 32'd1;
                end
                seq_counter        = seq_counter + 32'd1;
                ring_stamp[slot]   = w.stamp_ms;
                ring_seq[slot]     = seq_counter;
                ring_level[slot]   = w.level;
                ring_payload[slot] = w.payload;
                written_counter    = written_counter + 32'd1;
            end
            CMD_CLEAR:
                clear_trace_model();
            CMD_STATUS:
            begin
                r               = '0;
                r.kind          = KIND_STATUS;
                r.total_written = written_counter;
                r.total_dropped = dropped_counter;
                r.retained      = 6'(ring_held);
                r.last          = 1'b1;
                pending_words.push_back(r);
            end
            CMD_SNAPSHOT:
            begin
                n = (ring_held < int'(w.max_wanted)) ? ring_held : int'(w.max_wanted);
                if (n > MAX_RESULTS)
                    n = MAX_RESULTS;
                first = ring_held - n;
                for (int i = 0; i < n; i++)
                begin
                    slot           = (ring_oldest + first + i) % RING_DEPTH;
                    r              = '0;
                    r.kind         = KIND_ENTRY;
                    r.out_stamp_ms = ring_stamp[slot];
                    r.out_sequence = ring_seq[slot];
                    r.out_level    = ring_level[slot];
                    r.out_payload  = ring_payload[slot];
                    r.last         = (i + 1 == n);
                    pending_words.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Hold start high until the word is taken; the gap comes before the next one
    task automatic send_word(input otr_in_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        predict_trace_words(w);
        words_sent++;
    endtask

    task automatic wait_drained();
        if (start)
            start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word64();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic otr_in_t make_word(input logic [1:0] cmd, input logic [6:0] want);
        otr_in_t w;
        w.command    = cmd;
        w.level      = 3'($urandom);
        w.stamp_ms   = rand_word64();
        w.payload    = rand_word64();
        w.max_wanted = want;
        return w;
    endfunction

    function automatic otr_in_t make_append(input logic [2:0] lvl, input logic [63:0] stamp,
                                            input logic [63:0] pay);
        otr_in_t w;
        w            = make_word(CMD_APPEND, 7'($urandom));
        w.level      = lvl;
        w.stamp_ms   = stamp;
        w.payload    = pay;
        return w;
    endfunction

    function automatic logic [6:0] rand_want();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd64;
            2:       return 7'($urandom);
            default: return 7'($urandom_range(1, 33));
        endcase
    endfunction

    task automatic test_empty_ring();
        send_word(make_word(CMD_STATUS, 7'd0));
        send_word(make_word(CMD_SNAPSHOT, 7'd64));
        send_word(make_word(CMD_SNAPSHOT, 7'd0));
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        send_word(make_append(3'd0, 64'd0, 64'd0));
        send_word(make_append(3'd7, '1, '1));
        send_word(make_append(3'd5, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        send_word(make_append(3'd2, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
        send_word(make_word(CMD_SNAPSHOT, 7'd0));
        send_word(make_word(CMD_SNAPSHOT, 7'd2));
        send_word(make_word(CMD_SNAPSHOT, 7'd127));
        send_word(make_word(CMD_STATUS, 7'd127));
        send_word(make_word(CMD_CLEAR, 7'd64));
        send_word(make_word(CMD_STATUS, 7'd0));
        send_word(make_word(CMD_SNAPSHOT, 7'd1));
        send_word(make_append(3'd1, 64'd1, 64'd1));
        send_word(make_word(CMD_SNAPSHOT, 7'd1));
        wait_drained();
    endtask

    // Overfill so the oldest entries get overwritten, then read back the full ring
    task automatic test_wrap_around();
        int extra;
        send_word(make_word(CMD_CLEAR, 7'($urandom)));
        extra = $urandom_range(1, 40);
        for (int i = 0; i < RING_DEPTH + extra; i++)
            send_word(make_word(CMD_APPEND, 7'($urandom)));
        send_word(make_word(CMD_SNAPSHOT, 7'd64));
        send_word(make_word(CMD_STATUS, 7'($urandom)));
        send_word(make_word(CMD_SNAPSHOT, 7'($urandom_range(1, 32))));
        send_word(make_word(CMD_SNAPSHOT, 7'd32));
        send_word(make_word(CMD_SNAPSHOT, 7'd31));
        wait_drained();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        for (int i = 0; i < 60; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_word(make_word(($urandom_range(0, 1) == 0) ? CMD_SNAPSHOT : CMD_STATUS,
                                    rand_want()));
            else
                send_word(make_word(CMD_APPEND, 7'($urandom)));
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_noise();
        for (int i = 0; i < 40; i++)
            send_word(make_word(2'($urandom), 7'($urandom)));
        wait_drained();
    endtask

    // Bursts of appends followed by reads, with the odd clear and stray word
    task automatic test_mixed_sequences(input int target);
        int burst;
        int stop_at;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 8);
            for (int i = 0; i < burst; i++)
                send_word(make_word(CMD_APPEND, 7'($urandom)));
            send_word(make_word(CMD_SNAPSHOT, rand_want()));
            if ($urandom_range(0, 1) == 0)
                send_word(make_word(CMD_STATUS, 7'($urandom)));
            if ($urandom_range(0, 5) == 0)
                send_word(make_word(2'($urandom), 7'($urandom)));
            if ($urandom_range(0, 7) == 0)
                send_word(make_word(CMD_CLEAR, 7'($urandom)));
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            words_seen++;
            if (pending_words.size() == 0)
                report_error($sformatf("word %0d strobed with none expected", words_seen));
            else
            begin
                head_word = pending_words.pop_front();
                if (result.kind !== head_word.kind)
                    report_error($sformatf("word %0d kind got %h exp %h",
                                           words_seen, result.kind, head_word.kind));
                if (result.out_stamp_ms !== head_word.out_stamp_ms)
                    report_error($sformatf("word %0d out_stamp_ms got %h exp %h", words_seen,
                                           result.out_stamp_ms, head_word.out_stamp_ms));
                if (result.out_sequence !== head_word.out_sequence)
                    report_error($sformatf("word %0d out_sequence got %h exp %h", words_seen,
                                           result.out_sequence, head_word.out_sequence));
                if (result.out_level !== head_word.out_level)
                    report_error($sformatf("word %0d out_level got %h exp %h", words_seen,
                                           result.out_level, head_word.out_level));
                if (result.out_payload !== head_word.out_payload)
                    report_error($sformatf("word %0d out_payload got %h exp %h", words_seen,
                                           result.out_payload, head_word.out_payload));
                if (result.total_written !== head_word.total_written)
                    report_error($sformatf("word %0d total_written got %h exp %h", words_seen,
                                           result.total_written, head_word.total_written));
                if (result.total_dropped !== head_word.total_dropped)
                    report_error($sformatf("word %0d total_dropped got %h exp %h", words_seen,
                                           result.total_dropped, head_word.total_dropped));
                if (result.retained !== head_word.retained)
                    report_error($sformatf("word %0d retained got %h exp %h", words_seen,
                                           result.retained, head_word.retained));
                if (result.last !== head_word.last)
                    report_error($sformatf("word %0d last got %h exp %h",
                                           words_seen, result.last, head_word.last));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        clear_trace_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_directed_extremes();
        test_wrap_around();
        test_back_to_back();
        test_random_noise();
        test_mixed_sequences(420 - words_sent);

        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_words.size() != 0)
            report_error($sformatf("%0d expected words never arrived", pending_words.size()));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
